FILE: rtl/voxel_collision_and_ray_break_top_defines.svh
// assertion macros for the voxel collision and ray break block
`ifndef VOXEL_COLLISION_AND_RAY_BREAK_TOP_DEFINES_SVH
`define VOXEL_COLLISION_AND_RAY_BREAK_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define VCRB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define VCRB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/vcrb_pkg.sv
// shared types, constants and the sine table of the voxel collision block
`default_nettype none
package vcrb_pkg;

  localparam int GRID_XZ_DEF     = 16;
  localparam int GRID_HEIGHT_DEF = 128;
  localparam int RAY_STEPS_DEF   = 100;

  // Q8.8 body constants and Q8.16 step
  localparam logic signed [17:0] HALF_W_Q8 = 18'sd77;
  localparam logic signed [17:0] BODY_H_Q8 = 18'sd461;
  localparam logic signed [17:0] FOOT_Q8   = 18'sd26;
  localparam logic signed [27:0] EYE_Q8    = 28'sd415;
  localparam int                 STEP_Q16  = 3277;

  localparam int CW = 12;  // signed cell coordinate width
  localparam int DW = 14;  // signed per-step delta width
  localparam int AW_ACC = 28;  // ray accumulator width

  typedef enum logic [2:0] {
    CMD_WRITE = 3'd0,
    CMD_BOX   = 3'd1,
    CMD_FLOOR = 3'd2,
    CMD_GROUND = 3'd3,
    CMD_CEIL  = 3'd4,
    CMD_RAY   = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_SCAN, ST_SCHK, ST_DIR, ST_MARCH, ST_MCHK, ST_FIN
  } state_t;

  // ray step deltas from the direction unit
  typedef struct packed {
    logic                 done;
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic signed [DW-1:0] dz;
  } dir_res_t;

  // Q1.14 sine, one entry per degree from 0 to 90
  localparam logic [14:0] SINE_Q14 [91] = '{
    15'd0, 15'd286, 15'd572, 15'd857, 15'd1143, 15'd1428, 15'd1713, 15'd1997,
    15'd2280, 15'd2563, 15'd2845, 15'd3126, 15'd3406, 15'd3686, 15'd3964,
    15'd4240, 15'd4516, 15'd4790, 15'd5063, 15'd5334, 15'd5604, 15'd5872,
    15'd6138, 15'd6402, 15'd6664, 15'd6924, 15'd7182, 15'd7438, 15'd7692,
    15'd7943, 15'd8192, 15'd8438, 15'd8682, 15'd8923, 15'd9162, 15'd9397,
    15'd9630, 15'd9860, 15'd10087, 15'd10311, 15'd10531, 15'd10749,
    15'd10963, 15'd11174, 15'd11381, 15'd11585, 15'd11786, 15'd11982,
    15'd12176, 15'd12365, 15'd12551, 15'd12733, 15'd12911, 15'd13085,
    15'd13255, 15'd13421, 15'd13583, 15'd13741, 15'd13894, 15'd14044,
    15'd14189, 15'd14330, 15'd14466, 15'd14598, 15'd14726, 15'd14849,
    15'd14968, 15'd15082, 15'd15191, 15'd15296, 15'd15396, 15'd15491,
    15'd15582, 15'd15668, 15'd15749, 15'd15826, 15'd15897, 15'd15964,
    15'd16026, 15'd16083, 15'd16135, 15'd16182, 15'd16225, 15'd16262,
    15'd16294, 15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382,
    15'd16384
  };

  // sine of a whole degree in 0..359 by quadrant symmetry
  function automatic logic signed [15:0] sin_deg(input logic [8:0] d);
    logic [6:0] idx;
    logic       neg;
    begin
      if (d <= 9'd90) begin
        idx = d[6:0];
        neg = 1'b0;
      end else if (d <= 9'd180) begin
        idx = 7'(9'd180 - d);
        neg = 1'b0;
      end else if (d <= 9'd270) begin
        idx = 7'(d - 9'd180);
        neg = 1'b1;
      end else begin
        idx = 7'(9'd360 - d);
        neg = 1'b1;
      end
      sin_deg = neg ? -$signed({1'b0, SINE_Q14[idx]}) : $signed({1'b0, SINE_Q14[idx]});
    end
  endfunction

  // floor of a Q8.8 value to a cell coordinate
  function automatic logic signed [CW-1:0] floor_q8(input logic signed [17:0] v);
    floor_q8 = CW'(v >>> 8);
  endfunction

endpackage
`default_nettype wire

FILE: rtl/vcrb_ray_dir.sv
// ray direction unit: angles to per-step Q8.16 deltas, through a table lookup and product phases
`default_nettype none
module vcrb_ray_dir
  import vcrb_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic signed [7:0] pitch_deg,
  input  wire logic [8:0]        yaw_deg,
  output dir_res_t               res
);

  logic [2:0]         phase;
  logic [8:0]         pitch_r;
  logic [8:0]         yaw_r;
  logic signed [15:0] sp, cp, sy, cy;
  logic signed [31:0] p1, p2;
  logic signed [DW-1:0] dx, dy, dz;

  logic [9:0]  pitch_ext;
  logic [9:0]  pcos_arg, ycos_arg;
  logic [8:0]  pcos_deg, ycos_deg;
  logic signed [43:0] mx1, mx2;
  logic signed [29:0] my;

  // angle reduction, cosine arguments and step-scaled products
  always_comb begin
    pitch_ext = {{2{pitch_deg[7]}}, pitch_deg};
    pcos_arg  = {1'b0, pitch_r} + 10'd90;
    ycos_arg  = {1'b0, yaw_r} + 10'd90;
    pcos_deg  = (pcos_arg >= 10'd360) ? 9'(pcos_arg - 10'd360) : pcos_arg[8:0];
    ycos_deg  = (ycos_arg >= 10'd360) ? 9'(ycos_arg - 10'd360) : ycos_arg[8:0];
    mx1 = 44'(p1) * 44'sd3277;
    mx2 = 44'(p2) * 44'sd3277;
    my  = -(30'(sp) * 30'(STEP_Q16));
  end

  // phase sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 3'd0;
    end else if (start) begin
      phase <= 3'd1;
    end else if (phase != 3'd0) begin
      phase <= (phase == 3'd5) ? 3'd0 : phase + 3'd1;
    end
  end

  // table lookups, then one product stage after another
  always_ff @(posedge clk) begin
    if (start) begin
      pitch_r <= pitch_deg[7] ? 9'(pitch_ext + 10'd360) : {1'b0, pitch_deg};
      yaw_r   <= (yaw_deg >= 9'd360) ? 9'(yaw_deg - 9'd360) : yaw_deg;
    end
    if (phase == 3'd1) begin
      sp <= sin_deg(pitch_r);
      cp <= sin_deg(pcos_deg);
      sy <= sin_deg(yaw_r);
      cy <= sin_deg(ycos_deg);
    end
    if (phase == 3'd2) begin
      p1 <= sy * cp;
    end
    if (phase == 3'd3) begin
      p2 <= cy * cp;
      dx <= DW'(mx1 >>> 28);
    end
    if (phase == 3'd4) begin
      dz <= DW'((-mx2) >>> 28);
      dy <= DW'(my >>> 14);
    end
  end

  assign res.done = (phase == 3'd5);
  assign res.dx   = dx;
  assign res.dy   = dy;
  assign res.dz   = dz;

endmodule
`default_nettype wire

FILE: rtl/voxel_collision_and_ray_break_top.sv
// Top level: voxel grid store, collision scans and ray march with block break.
// After reset a clearing pass writes zero to all 2^(2*clog2(GRID_XZ)+clog2(GRID_HEIGHT))
// entries (32768 at defaults), one a cycle, with no request taken.
// Each box/floor/ground/ceiling cell is read in ST_SCAN and checked in ST_SCHK; a ray waits in
// ST_DIR for the direction unit, then steps in ST_MARCH and checks each in-grid cell in ST_MCHK.
// One request at a time; the voxel memory reads set the pace.
`default_nettype none
module voxel_collision_and_ray_break_top
  import vcrb_pkg::*;
#(
  parameter int GRID_XZ     = GRID_XZ_DEF,
  parameter int GRID_HEIGHT = GRID_HEIGHT_DEF,
  parameter int RAY_STEPS   = RAY_STEPS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // pos_x, pos_y, pos_z, cell_x, cell_y, cell_z, block_value, pitch_deg, yaw_deg
  input  wire logic [95:0] s_tdata,
  // cmd
  input  wire logic [2:0]  s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // hit
  output logic [7:0]       m_tdata
);

  localparam int XW = $clog2(GRID_XZ);
  localparam int YW = $clog2(GRID_HEIGHT);
  localparam int AW = 2 * XW + YW;
  localparam int SW = $clog2(RAY_STEPS + 1);

  // request fields
  logic [2:0]         f_cmd;
  logic signed [16:0] f_px, f_py, f_pz;
  logic [3:0]         f_cx, f_cz;
  logic [6:0]         f_cy;
  logic [7:0]         f_val;
  logic signed [7:0]  f_pitch;
  logic [8:0]         f_yaw;

  assign f_cmd   = s_tuser;
  assign f_px    = s_tdata[16:0];
  assign f_py    = s_tdata[33:17];
  assign f_pz    = s_tdata[50:34];
  assign f_cx    = s_tdata[54:51];
  assign f_cy    = s_tdata[61:55];
  assign f_cz    = s_tdata[65:62];
  assign f_val   = s_tdata[73:66];
  assign f_pitch = s_tdata[81:74];
  assign f_yaw   = s_tdata[90:82];

  state_t state, state_next;
  logic   accept;
  logic   res_hit;

  logic [AW-1:0] clr_cnt;
  logic [7:0]    mem [2**AW];
  logic [7:0]    rdata;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]    mem_wdata;

  logic signed [CW-1:0] x0, x1, y0, y1, z0, z1, cx, cy, cz;
  logic signed [AW_ACC-1:0] rx, ry, rz, nrx, nry, nrz;
  logic signed [CW-1:0] bx, by, bz;
  logic [SW-1:0] scnt;
  logic [AW-1:0] ray_addr;
  logic          dir_start;
  dir_res_t      dir;

  logic signed [CW-1:0] lo_x, hi_x, lo_y, hi_y, lo_z, hi_z;
  logic cur_in, next_in, wr_in, scan_last, ray_last;

  function automatic logic in_grid(input logic signed [CW-1:0] x,
                                   input logic signed [CW-1:0] y,
                                   input logic signed [CW-1:0] z);
    in_grid = !x[CW-1] && (x < CW'(GRID_XZ)) && !y[CW-1] && (y < CW'(GRID_HEIGHT)) &&
              !z[CW-1] && (z < CW'(GRID_XZ));
  endfunction

  function automatic logic [AW-1:0] addr_of(input logic signed [CW-1:0] x,
                                            input logic signed [CW-1:0] y,
                                            input logic signed [CW-1:0] z);
    addr_of = {x[XW-1:0], y[YW-1:0], z[XW-1:0]};
  endfunction

  assign accept = s_tvalid && s_tready;

  // scan bounds for the four collision queries
  always_comb begin
    lo_x = floor_q8(18'(f_px) - HALF_W_Q8);
    hi_x = floor_q8(18'(f_px) + HALF_W_Q8);
    lo_z = floor_q8(18'(f_pz) - HALF_W_Q8);
    hi_z = floor_q8(18'(f_pz) + HALF_W_Q8);
    lo_y = floor_q8(18'(f_py));
    hi_y = floor_q8(18'(f_py) + BODY_H_Q8);
    unique case (f_cmd)
      CMD_FLOOR: begin
        lo_y = floor_q8(18'(f_py) - FOOT_Q8);
        hi_y = lo_y;
      end
      CMD_GROUND: begin
        lo_x = floor_q8(18'(f_px));
        hi_x = lo_x;
        lo_z = floor_q8(18'(f_pz));
        hi_z = lo_z;
        lo_y = floor_q8(18'(f_py) - FOOT_Q8);
        hi_y = lo_y;
      end
      CMD_CEIL: begin
        lo_x = floor_q8(18'(f_px));
        hi_x = lo_x;
        lo_z = floor_q8(18'(f_pz));
        hi_z = lo_z;
        lo_y = hi_y;
      end
      default: begin
      end
    endcase
  end

  // ray step and cell tests
  always_comb begin
    nrx = rx + AW_ACC'(dir.dx);
    nry = ry + AW_ACC'(dir.dy);
    nrz = rz + AW_ACC'(dir.dz);
    bx  = nrx[AW_ACC-1:16];
    by  = nry[AW_ACC-1:16];
    bz  = nrz[AW_ACC-1:16];
    next_in   = in_grid(bx, by, bz);
    cur_in    = in_grid(cx, cy, cz);
    wr_in     = in_grid(CW'(f_cx), CW'(f_cy), CW'(f_cz));
    scan_last = (cx == x1) && (cy == y1) && (cz == z1);
    ray_last  = (scnt == SW'(RAY_STEPS - 1));
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (&clr_cnt) state_next = ST_IDLE;
      ST_IDLE: begin
        if (s_tvalid) begin
          unique case (f_cmd)
            CMD_BOX, CMD_FLOOR, CMD_GROUND, CMD_CEIL: state_next = ST_SCAN;
            CMD_RAY: state_next = ST_DIR;
            default: state_next = ST_FIN;
          endcase
        end
      end
      ST_SCAN: state_next = cur_in ? ST_SCHK : ST_FIN;
      ST_SCHK: if (rdata != 8'd0 || scan_last) state_next = ST_FIN;
               else state_next = ST_SCAN;
      ST_DIR: if (dir.done) state_next = ST_MARCH;
      ST_MARCH: begin
        if (next_in) state_next = ST_MCHK;
        else if (ray_last) state_next = ST_FIN;
      end
      ST_MCHK: begin
        if (rdata != 8'd0 || scnt == SW'(RAY_STEPS)) state_next = ST_FIN;
        else state_next = ST_MARCH;
      end
      ST_FIN: if (!m_tvalid || m_tready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // memory port and handshake controls
  always_comb begin
    s_tready  = (state == ST_IDLE);
    dir_start = accept && (f_cmd == CMD_RAY);
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = clr_cnt;
    mem_wdata = 8'd0;
    mem_raddr = addr_of(cx, cy, cz);
    unique case (state)
      ST_CLEAR: mem_we = 1'b1;
      ST_IDLE: begin
        mem_waddr = addr_of(CW'(f_cx), CW'(f_cy), CW'(f_cz));
        mem_wdata = f_val;
        mem_we    = accept && (f_cmd == CMD_WRITE) && wr_in;
      end
      ST_SCAN: mem_re = cur_in;
      ST_MARCH: begin
        mem_raddr = addr_of(bx, by, bz);
        mem_re    = next_in;
      end
      ST_MCHK: begin
        mem_waddr = ray_addr;
        mem_we    = (rdata != 8'd0);
      end
      default: begin
      end
    endcase
  end

  // voxel store
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata <= mem[mem_raddr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_cnt  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_cnt <= clr_cnt + 1'b1;
      if (state == ST_FIN && (!m_tvalid || m_tready)) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      res_hit <= 1'b0;
      x0 <= lo_x; x1 <= hi_x; y0 <= lo_y; y1 <= hi_y; z0 <= lo_z; z1 <= hi_z;
      cx <= lo_x; cy <= lo_y; cz <= lo_z;
      rx <= AW_ACC'(f_px) <<< 8;
      ry <= (AW_ACC'(f_py) + EYE_Q8) <<< 8;
      rz <= AW_ACC'(f_pz) <<< 8;
      scnt <= '0;
    end
    if (state == ST_SCAN && !cur_in) res_hit <= 1'b1;
    if (state == ST_SCHK) begin
      if (rdata != 8'd0) begin
        res_hit <= 1'b1;
      end else if (cz != z1) begin
        cz <= cz + 1'b1;
      end else begin
        cz <= z0;
        if (cy != y1) begin
          cy <= cy + 1'b1;
        end else begin
          cy <= y0;
          cx <= cx + 1'b1;
        end
      end
    end
    if (state == ST_MARCH) begin
      rx <= nrx; ry <= nry; rz <= nrz;
      scnt <= scnt + 1'b1;
      ray_addr <= addr_of(bx, by, bz);
    end
    if (state == ST_MCHK && rdata != 8'd0) res_hit <= 1'b1;
    if (state == ST_FIN && (!m_tvalid || m_tready)) m_tdata <= {7'd0, res_hit};
  end

  vcrb_ray_dir u_dir (
    .clk       (clk),
    .rst       (rst),
    .start     (dir_start),
    .pitch_deg (f_pitch),
    .yaw_deg   (f_yaw),
    .res       (dir)
  );

endmodule
`default_nettype wire

FILE: rtl/vcrb_checker.sv
// port checker for the voxel collision block and its bind
`default_nettype none
`include "voxel_collision_and_ray_break_top_defines.svh"
module vcrb_checker
  import vcrb_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic [95:0] s_tdata,
  input wire logic [2:0]  s_tuser,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [7:0]  m_tdata
);

  // a stalled result holds
  `VCRB_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped while stalled")

  // one request at a time: busy right after a request
  `VCRB_ASSERT_NXT(a_busy, s_tvalid && s_tready, !s_tready, "request taken while busy")

  // only the hit bit is ever set
  `VCRB_ASSERT_IMP(a_pad, m_tvalid, m_tdata[7:1] == 7'd0, "result padding not zero")

  // a write request gives no hit
  `VCRB_ASSERT_IMP(a_write_nohit, $past(s_tvalid && s_tready && s_tuser == CMD_WRITE, 2) && $rose(m_tvalid), m_tdata[0] == 1'b0, "write request reported a hit")

endmodule

bind voxel_collision_and_ray_break_top vcrb_checker u_vcrb_checker (.*);
`default_nettype wire
